FILE: rtl/sqg_pkg.sv
// shared types, codes and arithmetic helpers of the single-qubit gate engine
package sqg_pkg;

   localparam int QUBITS_DEFAULT = 10;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [2:0] MODE_WRITE    = 3'd0;
   localparam logic [2:0] MODE_READ     = 3'd1;
   localparam logic [2:0] MODE_GENERAL  = 3'd2;
   localparam logic [2:0] MODE_DIAGONAL = 3'd3;
   localparam logic [2:0] MODE_ANTIDIAG = 3'd4;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_M00_RE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_M00_IM = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_M01_RE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_M01_IM = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_M10_RE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_M10_IM = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_M11_RE = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_M11_IM = 3'd7;

   localparam logic signed [15:0] Q14_ONE  = 16'sd16384;
   localparam logic signed [15:0] Q14_ZERO = 16'sd0;

   typedef struct packed {
      logic [2:0]         mode;
      logic [9:0]         amp_index;
      logic signed [15:0] write_re;
      logic signed [15:0] write_im;
      logic [4:0]         gate_target;
   } req_type;

   typedef struct packed {
      logic signed [15:0] read_re;
      logic signed [15:0] read_im;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] re;
      logic signed [15:0] im;
   } amp_type;

   typedef struct packed {
      amp_type m00;
      amp_type m01;
      amp_type m10;
      amp_type m11;
   } coef_type;

   // q4.28 product to q2.14, ties toward plus infinity
   function automatic logic signed [18:0] round_q14(input logic signed [31:0] p);
      logic signed [32:0] s;
      s = 33'(p) + 33'sd8192;
      return 19'(s >>> 14);
   endfunction

   function automatic logic signed [15:0] sat_q14(input logic signed [20:0] v);
      logic signed [15:0] r;
      if (v > 21'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -21'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

endpackage

FILE: rtl/sqg_bank.sv
// one bank of amplitude storage, one write port and one registered read port
module sqg_bank #(
   parameter int AW = sqg_pkg::QUBITS_DEFAULT - 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  sqg_pkg::amp_type wdata,
   input  logic [AW-1:0]    raddr,
   output sqg_pkg::amp_type rdata
);

   sqg_pkg::amp_type mem [2**AW];
   sqg_pkg::amp_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/sqg_pair.sv
// two-stage complex 2x2 matrix times amplitude pair: products, then round, sum, saturate
module sqg_pair (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  sqg_pkg::coef_type coef,
   input  sqg_pkg::amp_type  z,
   input  sqg_pkg::amp_type  o,
   output logic              out_valid,
   output sqg_pkg::amp_type  z_new,
   output sqg_pkg::amp_type  o_new,
   output logic              busy
);

   sqg_pkg::amp_type   x [4];
   sqg_pkg::amp_type   y [4];
   logic signed [31:0] p_in [16];
   logic signed [31:0] p_ff [16];
   logic signed [20:0] t_re [4];
   logic signed [20:0] t_im [4];
   logic               v1_ff;
   logic               v2_ff;
   sqg_pkg::amp_type   z_in;
   sqg_pkg::amp_type   o_in;
   sqg_pkg::amp_type   z_ff;
   sqg_pkg::amp_type   o_ff;

   // lanes: m00*z, m01*o, m10*z, m11*o
   always_comb begin
      x[0] = coef.m00;
      x[1] = coef.m01;
      x[2] = coef.m10;
      x[3] = coef.m11;
      y[0] = z;
      y[1] = o;
      y[2] = z;
      y[3] = o;
      for (int l = 0; l < 4; l++) begin
         p_in[4*l]   = 32'(x[l].re) * 32'(y[l].re);
         p_in[4*l+1] = 32'(x[l].im) * 32'(y[l].im);
         p_in[4*l+2] = 32'(x[l].re) * 32'(y[l].im);
         p_in[4*l+3] = 32'(x[l].im) * 32'(y[l].re);
      end
   end

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         t_re[l] = 21'(sqg_pkg::round_q14(p_ff[4*l]))
                 - 21'(sqg_pkg::round_q14(p_ff[4*l+1]));
         t_im[l] = 21'(sqg_pkg::round_q14(p_ff[4*l+2]))
                 + 21'(sqg_pkg::round_q14(p_ff[4*l+3]));
      end
      z_in.re = sqg_pkg::sat_q14(t_re[0] + t_re[1]);
      z_in.im = sqg_pkg::sat_q14(t_im[0] + t_im[1]);
      o_in.re = sqg_pkg::sat_q14(t_re[2] + t_re[3]);
      o_in.im = sqg_pkg::sat_q14(t_im[2] + t_im[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      z_ff <= z_in;
      o_ff <= o_in;
   end

   assign out_valid = v2_ff;
   assign z_new     = z_ff;
   assign o_new     = o_ff;
   assign busy      = v1_ff | v2_ff;

endmodule

FILE: rtl/single_qubit_gate_state_vector.sv
// Single-qubit gate engine over a state vector of 2^QUBITS complex Q2.14 amplitudes.
// The vector sits in two banks split by the parity of the amplitude index, so the two
// amplitudes of any pair always lie in different banks; each bank has one write and one
// registered read port. A write item goes straight to the response state, a read item
// first through the read state. A gate item streams one amplitude pair per cycle
// through a read, multiply, round-and-sum, write-back pipeline; the pair count is set
// by the single pass over the banks. A gate with a target at or beyond QUBITS, and an
// unused mode, go straight to the response state. One item is worked on at a time; a
// new item is taken while the last result waits. The user must write matrix registers
// through the csr port while the engine is idle; the block does not enforce this.
module single_qubit_gate_state_vector #(
   parameter int QUBITS = sqg_pkg::QUBITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sqg_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sqg_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sqg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_data
);

   localparam int AW    = QUBITS;
   localparam int BAW   = (QUBITS > 1) ? QUBITS - 1 : 1;
   localparam int PAIRS = 2**(QUBITS - 1);
   localparam logic [BAW-1:0] LAST_PAIR = BAW'(PAIRS - 1);

   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_GATE, ST_DRAIN, ST_RESP} state_type;

   state_type         state_ff, state_in;
   logic [BAW-1:0]    cnt_ff, cnt_in;
   logic [4:0]        tgt_ff, tgt_in;
   sqg_pkg::coef_type mat_ff, mat_in;
   sqg_pkg::coef_type coef_ff, coef_in;
   sqg_pkg::rsp_type  res_ff, res_in;
   sqg_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rd_bank_ff, rd_bank_in;
   logic              m1_valid_ff;

   logic              m1_swap_ff, m2_swap_ff, m3_swap_ff;
   logic [BAW-1:0]    m1_a0_ff, m2_a0_ff, m3_a0_ff;
   logic [BAW-1:0]    m1_a1_ff, m2_a1_ff, m3_a1_ff;

   logic              accept;
   logic [AW-1:0]     idx;
   logic              par_idx;
   logic [BAW-1:0]    baddr_idx;
   logic              tgt_ok;
   logic [AW-1:0]     cext;
   logic [AW-1:0]     mask_lo;
   logic [AW-1:0]     tbit;
   logic [AW-1:0]     j_idx;
   logic [AW-1:0]     k_idx;
   logic              par_j;
   logic [BAW-1:0]    g_a0;
   logic [BAW-1:0]    g_a1;
   logic              issue;

   logic [BAW-1:0]    raddr0, raddr1;
   logic [BAW-1:0]    waddr0, waddr1;
   logic              we0, we1;
   sqg_pkg::amp_type  wdata0, wdata1;
   sqg_pkg::amp_type  rdata0, rdata1;
   sqg_pkg::amp_type  wr_amp;

   sqg_pkg::amp_type  pz, po;
   logic              pair_valid;
   sqg_pkg::amp_type  z_new, o_new;
   logic              pair_busy;

   // item decode
   assign accept    = req_valid && req_ready;
   assign idx       = AW'(req_data.amp_index);
   assign par_idx   = ^idx;
   assign baddr_idx = BAW'(idx >> 1);
   assign tgt_ok    = req_data.gate_target < 5'(QUBITS);
   assign wr_amp.re = req_data.write_re;
   assign wr_amp.im = req_data.write_im;

   // pair number to index pair: a zero bit is inserted at the target position
   assign cext    = AW'(cnt_ff);
   assign tbit    = AW'(1) << tgt_ff;
   assign mask_lo = tbit - AW'(1);
   assign j_idx   = (cext & mask_lo) | ((cext & ~mask_lo) << 1);
   assign k_idx   = j_idx | tbit;
   assign par_j   = ^j_idx;
   assign g_a0    = par_j ? BAW'(k_idx >> 1) : BAW'(j_idx >> 1);
   assign g_a1    = par_j ? BAW'(j_idx >> 1) : BAW'(k_idx >> 1);
   assign issue   = state_ff == ST_GATE;

   assign raddr0 = issue ? g_a0 : baddr_idx;
   assign raddr1 = issue ? g_a1 : baddr_idx;

   always_comb begin
      if (pair_valid) begin
         we0    = 1'b1;
         we1    = 1'b1;
         waddr0 = m3_a0_ff;
         waddr1 = m3_a1_ff;
         wdata0 = m3_swap_ff ? o_new : z_new;
         wdata1 = m3_swap_ff ? z_new : o_new;
      end else begin
         we0    = accept && (req_data.mode == sqg_pkg::MODE_WRITE) && !par_idx;
         we1    = accept && (req_data.mode == sqg_pkg::MODE_WRITE) && par_idx;
         waddr0 = baddr_idx;
         waddr1 = baddr_idx;
         wdata0 = wr_amp;
         wdata1 = wr_amp;
      end
   end

   sqg_bank #(.AW(BAW)) u_bank0 (
      .clock (clock),
      .we    (we0),
      .waddr (waddr0),
      .wdata (wdata0),
      .raddr (raddr0),
      .rdata (rdata0)
   );

   sqg_bank #(.AW(BAW)) u_bank1 (
      .clock (clock),
      .we    (we1),
      .waddr (waddr1),
      .wdata (wdata1),
      .raddr (raddr1),
      .rdata (rdata1)
   );

   assign pz = m1_swap_ff ? rdata1 : rdata0;
   assign po = m1_swap_ff ? rdata0 : rdata1;

   sqg_pair u_pair (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m1_valid_ff),
      .coef      (coef_ff),
      .z         (pz),
      .o         (po),
      .out_valid (pair_valid),
      .z_new     (z_new),
      .o_new     (o_new),
      .busy      (pair_busy)
   );

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      tgt_in       = tgt_ff;
      mat_in       = mat_ff;
      coef_in      = coef_ff;
      res_in       = res_ff;
      rd_bank_in   = rd_bank_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_valid) begin
         unique case (csr_index)
            sqg_pkg::CSR_M00_RE: mat_in.m00.re = csr_data;
            sqg_pkg::CSR_M00_IM: mat_in.m00.im = csr_data;
            sqg_pkg::CSR_M01_RE: mat_in.m01.re = csr_data;
            sqg_pkg::CSR_M01_IM: mat_in.m01.im = csr_data;
            sqg_pkg::CSR_M10_RE: mat_in.m10.re = csr_data;
            sqg_pkg::CSR_M10_IM: mat_in.m10.im = csr_data;
            sqg_pkg::CSR_M11_RE: mat_in.m11.re = csr_data;
            sqg_pkg::CSR_M11_IM: mat_in.m11.im = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               unique case (req_data.mode) inside
                  sqg_pkg::MODE_WRITE: begin
                     state_in = ST_RESP;
                  end
                  sqg_pkg::MODE_READ: begin
                     rd_bank_in = par_idx;
                     state_in   = ST_READ;
                  end
                  sqg_pkg::MODE_GENERAL, sqg_pkg::MODE_DIAGONAL,
                  sqg_pkg::MODE_ANTIDIAG: begin
                     if (tgt_ok) begin
                        tgt_in  = req_data.gate_target;
                        cnt_in  = '0;
                        coef_in = mat_ff;
                        if (req_data.mode == sqg_pkg::MODE_DIAGONAL) begin
                           coef_in.m01 = '0;
                           coef_in.m10 = '0;
                        end
                        if (req_data.mode == sqg_pkg::MODE_ANTIDIAG) begin
                           coef_in.m00 = '0;
                           coef_in.m11 = '0;
                        end
                        state_in = ST_GATE;
                     end else begin
                        res_in.status = sqg_pkg::STATUS_RANGE;
                        state_in      = ST_RESP;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in.read_re = rd_bank_ff ? rdata1.re : rdata0.re;
            res_in.read_im = rd_bank_ff ? rdata1.im : rdata0.im;
            res_in.status  = sqg_pkg::STATUS_DONE;
            state_in       = ST_RESP;
         end
         ST_GATE: begin
            cnt_in = cnt_ff + BAW'(1);
            if (cnt_ff == LAST_PAIR) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!m1_valid_ff && !pair_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mat_ff.m00   <= '{re: sqg_pkg::Q14_ONE,  im: sqg_pkg::Q14_ZERO};
         mat_ff.m01   <= '{re: sqg_pkg::Q14_ZERO, im: sqg_pkg::Q14_ZERO};
         mat_ff.m10   <= '{re: sqg_pkg::Q14_ZERO, im: sqg_pkg::Q14_ZERO};
         mat_ff.m11   <= '{re: sqg_pkg::Q14_ONE,  im: sqg_pkg::Q14_ZERO};
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mat_ff       <= mat_in;
      end
      tgt_ff      <= tgt_in;
      coef_ff     <= coef_in;
      res_ff      <= res_in;
      rd_bank_ff  <= rd_bank_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pair addresses travel alongside the arithmetic pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= issue;
      end
      m1_swap_ff <= par_j;
      m1_a0_ff   <= g_a0;
      m1_a1_ff   <= g_a1;
      m2_swap_ff <= m1_swap_ff;
      m2_a0_ff   <= m1_a0_ff;
      m2_a1_ff   <= m1_a1_ff;
      m3_swap_ff <= m2_swap_ff;
      m3_a0_ff   <= m2_a0_ff;
      m3_a1_ff   <= m2_a1_ff;
   end

`ifndef SYNTHESIS
   a_wb_in_gate: assert property (@(posedge clock) disable iff (reset)
      pair_valid |-> (state_ff == ST_GATE || state_ff == ST_DRAIN))
      else $error("gate write-back outside of a gate");

   a_write_done: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.mode == sqg_pkg::MODE_WRITE) |=> state_ff == ST_RESP)
      else $error("write item did not finish");

   a_last_pair: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GATE && cnt_ff == LAST_PAIR) |=>
      (state_ff == ST_DRAIN && cnt_ff == '0))
      else $error("gate did not stop after the last pair");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && (!rsp_valid || rsp_ready)) |=>
      (rsp_valid && state_ff == ST_IDLE))
      else $error("result not presented");
`endif

endmodule
